// File: rtl/png_scanline_unfilter_assert.svh
// ----------------------------------------------------------------------------
// PNG scanline unfilter assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PNGU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PNGU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pngu_pkg.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Field widths, register indexes, filter codes and the Paeth predictor.
// ----------------------------------------------------------------------------
package pngu_pkg;

   // Field and register widths.
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned WIDTH_REG_W = 11;
   localparam int unsigned HEIGHT_W    = 16;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned CSR_INDEX_W = 1;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Filter types of a row.
   localparam logic [BYTE_W-1:0] FILTER_NONE    = 8'd0;
   localparam logic [BYTE_W-1:0] FILTER_SUB     = 8'd1;
   localparam logic [BYTE_W-1:0] FILTER_UP      = 8'd2;
   localparam logic [BYTE_W-1:0] FILTER_AVERAGE = 8'd3;
   localparam logic [BYTE_W-1:0] FILTER_PAETH   = 8'd4;

   // Paeth predictor: picks the neighbour nearest to a + b - c.
   function automatic logic [BYTE_W-1:0] paeth_predict(
      input logic [BYTE_W-1:0] a,
      input logic [BYTE_W-1:0] b,
      input logic [BYTE_W-1:0] c
   );
      logic signed [BYTE_W+2:0] sa;
      logic signed [BYTE_W+2:0] sb;
      logic signed [BYTE_W+2:0] sc;
      logic signed [BYTE_W+2:0] da;
      logic signed [BYTE_W+2:0] db;
      logic signed [BYTE_W+2:0] dc;
      logic        [BYTE_W+2:0] pa;
      logic        [BYTE_W+2:0] pb;
      logic        [BYTE_W+2:0] pc;
      sa = signed'({3'b000, a});
      sb = signed'({3'b000, b});
      sc = signed'({3'b000, c});
      // p - a = b - c, p - b = a - c, p - c = a + b - 2c.
      da = sb - sc;
      db = sa - sc;
      dc = sa + sb - sc - sc;
      pa = unsigned'(da < 0 ? -da : da);
      pb = unsigned'(db < 0 ? -db : db);
      pc = unsigned'(dc < 0 ? -dc : dc);
      if (pa <= pb && pa <= pc) begin
         return a;
      end else if (pb <= pc) begin
         return b;
      end else begin
         return c;
      end
   endfunction

endpackage

// File: rtl/pngu_req_if.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter input channel
// Valid/ready channel carrying one byte of the inflated stream per item.
// ----------------------------------------------------------------------------
interface pngu_req_if;
   import pngu_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// File: rtl/pngu_rsp_if.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter result channel
// Valid/ready channel carrying one reconstructed byte or error per item.
// ----------------------------------------------------------------------------
interface pngu_rsp_if;
   import pngu_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] pixel_byte;
   logic              row_end;
   logic              image_end;
   logic              bad_filter;

   modport source (output valid, output pixel_byte, output row_end, output image_end,
                   output bad_filter, input ready);
   modport sink   (input valid, input pixel_byte, input row_end, input image_end,
                   input bad_filter, output ready);
endinterface

// File: rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Rebuilds 8-bit RGBA rows from the filtered, inflated PNG byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle unless the result side stalls, and
// gives one result per sample byte through the input register, then the
// result register. Filter-type bytes give no result, except an unknown type,
// which gives a single error item and drops the rest of its row. The previous
// row lives in a single-port-write line store of MAX_WIDTH_PIXELS*BYTES_PER_PIXEL
// bytes whose registered read is issued ahead at the next column, so the up
// neighbour is ready when the byte is processed; the store needs no clearing
// because the first row of each image reads zeros from above. Width and
// height registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
   parameter int unsigned MAX_WIDTH_PIXELS = 1024,
   parameter int unsigned BYTES_PER_PIXEL  = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [pngu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pngu_pkg::CSR_DATA_W-1:0]     csr_wdata,
   pngu_req_if.sink                            req_chan,
   pngu_rsp_if.source                          rsp_chan
);
   import pngu_pkg::*;

   `include "png_scanline_unfilter_assert.svh"

   localparam int unsigned STORE_DEPTH = MAX_WIDTH_PIXELS * BYTES_PER_PIXEL;
   localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1) + 1;
   localparam int unsigned HIST_W      = BYTE_W * BYTES_PER_PIXEL;

   // Configuration registers.
   logic [WIDTH_REG_W-1:0] width_reg_ff;
   logic [HEIGHT_W-1:0]    height_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= WIDTH_REG_W'(1);
         height_reg_ff <= HEIGHT_W'(1);
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_reg_ff  <= csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_reg_ff <= csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective row length in bytes and image height.
   logic [31:0]         width_clamped;
   logic [CNT_W-1:0]    stride;
   logic [HEIGHT_W-1:0] height_eff;

   always_comb begin
      width_clamped = {{(32-WIDTH_REG_W){1'b0}}, width_reg_ff};
      if (width_clamped == 32'd0) begin
         width_clamped = 32'd1;
      end else if (width_clamped > 32'(MAX_WIDTH_PIXELS)) begin
         width_clamped = 32'(MAX_WIDTH_PIXELS);
      end
      stride     = CNT_W'(width_clamped * 32'(BYTES_PER_PIXEL));
      height_eff = (height_reg_ff == '0) ? HEIGHT_W'(1) : height_reg_ff;
   end

   // Input register.
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_start_ff;
   logic              fire;

   assign req_chan.ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff  <= req_chan.data_byte;
         in_start_ff <= req_chan.frame_start;
      end
   end

   // Row state.
   logic [ADDR_W-1:0]   column_ff,       column_in;
   logic [HEIGHT_W-1:0] row_count_ff,    row_count_in;
   logic [2:0]          row_filter_ff,   row_filter_in;
   logic                awaiting_ff,     awaiting_in;
   logic                dropping_ff,     dropping_in;
   logic [HIST_W-1:0]   left_ff,         left_in;
   logic [HIST_W-1:0]   upper_left_ff,   upper_left_in;

   // Result register.
   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff,  out_byte_in;
   logic              out_row_end_ff, out_row_end_in;
   logic              out_img_end_ff, out_img_end_in;
   logic              out_bad_ff,     out_bad_in;
   logic              out_load;
   logic              out_free;

   // Line store with registered read and a write-through path.
   logic [BYTE_W-1:0] line_store [STORE_DEPTH];
   logic [BYTE_W-1:0] store_rdata_ff;
   logic              store_wr_en;
   logic [BYTE_W-1:0] store_wdata;
   logic              bypass_ff;
   logic [BYTE_W-1:0] bypass_data_ff;
   logic [BYTE_W-1:0] up_byte;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign fire     = in_valid_ff && out_free;

   always_ff @(posedge clock) begin
      if (store_wr_en) begin
         line_store[column_ff] <= store_wdata;
      end
      store_rdata_ff <= line_store[column_in];
   end

   always_ff @(posedge clock) begin
      bypass_ff      <= store_wr_en && (column_ff == column_in);
      bypass_data_ff <= store_wdata;
   end

   assign up_byte = bypass_ff ? bypass_data_ff : store_rdata_ff;

   // Reconstruction of one byte and the next row state.
   logic [ADDR_W-1:0]   col0;
   logic [HEIGHT_W-1:0] row0;
   logic [HIST_W-1:0]   left0;
   logic [HIST_W-1:0]   upper_left0;
   logic                await0;
   logic                drop0;
   logic                last_col;
   logic                last_row;
   logic [HEIGHT_W-1:0] row_next;
   logic [BYTE_W-1:0]   a_byte;
   logic [BYTE_W-1:0]   b_byte;
   logic [BYTE_W-1:0]   c_byte;
   logic [BYTE_W:0]     ab_sum;
   logic [BYTE_W-1:0]   pred;
   logic [BYTE_W-1:0]   recon;

   always_comb begin
      // A frame start restarts the image at this byte.
      col0        = in_start_ff ? '0 : column_ff;
      row0        = in_start_ff ? '0 : row_count_ff;
      left0       = in_start_ff ? '0 : left_ff;
      upper_left0 = in_start_ff ? '0 : upper_left_ff;
      await0      = in_start_ff || awaiting_ff;
      drop0       = in_start_ff ? 1'b0 : dropping_ff;

      last_col = ({{(CNT_W-ADDR_W){1'b0}}, col0} + CNT_W'(1)) >= stride;
      last_row = ({1'b0, row0} + (HEIGHT_W+1)'(1)) >= {1'b0, height_eff};
      row_next = last_row ? '0 : row0 + HEIGHT_W'(1);

      a_byte = left0[HIST_W-1 -: BYTE_W];
      c_byte = upper_left0[HIST_W-1 -: BYTE_W];
      b_byte = (row0 == '0) ? '0 : up_byte;
      ab_sum = {1'b0, a_byte} + {1'b0, b_byte};

      case (row_filter_ff)
         FILTER_SUB[2:0]:     pred = a_byte;
         FILTER_UP[2:0]:      pred = b_byte;
         FILTER_AVERAGE[2:0]: pred = ab_sum[BYTE_W:1];
         FILTER_PAETH[2:0]:   pred = paeth_predict(a_byte, b_byte, c_byte);
         default:             pred = '0;
      endcase
      recon = in_byte_ff + pred;

      column_in      = column_ff;
      row_count_in   = row_count_ff;
      row_filter_in  = row_filter_ff;
      awaiting_in    = awaiting_ff;
      dropping_in    = dropping_ff;
      left_in        = left_ff;
      upper_left_in  = upper_left_ff;
      out_load       = 1'b0;
      out_byte_in    = recon;
      out_row_end_in = last_col;
      out_img_end_in = last_col && last_row;
      out_bad_in     = 1'b0;
      store_wr_en    = 1'b0;
      store_wdata    = recon;

      if (fire) begin
         column_in     = col0;
         row_count_in  = row0;
         awaiting_in   = await0;
         dropping_in   = drop0;
         left_in       = left0;
         upper_left_in = upper_left0;
         if (await0) begin
            // Filter-type byte: an unknown type yields one error item.
            awaiting_in = 1'b0;
            if (in_byte_ff > FILTER_PAETH) begin
               dropping_in    = 1'b1;
               out_load       = 1'b1;
               out_byte_in    = '0;
               out_row_end_in = 1'b0;
               out_img_end_in = 1'b0;
               out_bad_in     = 1'b1;
            end else begin
               row_filter_in = in_byte_ff[2:0];
            end
         end else begin
            if (!drop0) begin
               out_load      = 1'b1;
               store_wr_en   = 1'b1;
               left_in       = {left0[HIST_W-BYTE_W-1:0], recon};
               upper_left_in = {upper_left0[HIST_W-BYTE_W-1:0], b_byte};
            end
            if (last_col) begin
               // Close the row and wait for the next filter byte.
               row_count_in  = row_next;
               column_in     = '0;
               left_in       = '0;
               upper_left_in = '0;
               awaiting_in   = 1'b1;
               dropping_in   = 1'b0;
            end else begin
               column_in = col0 + ADDR_W'(1);
            end
         end
      end
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         row_count_ff  <= '0;
         row_filter_ff <= '0;
         awaiting_ff   <= 1'b1;
         dropping_ff   <= 1'b0;
         left_ff       <= '0;
         upper_left_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         column_ff     <= column_in;
         row_count_ff  <= row_count_in;
         row_filter_ff <= row_filter_in;
         awaiting_ff   <= awaiting_in;
         dropping_ff   <= dropping_in;
         left_ff       <= left_in;
         upper_left_ff <= upper_left_in;
         if (out_free) begin
            out_valid_ff <= out_load;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_byte_ff    <= out_byte_in;
         out_row_end_ff <= out_row_end_in;
         out_img_end_ff <= out_img_end_in;
         out_bad_ff     <= out_bad_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.pixel_byte = out_byte_ff;
   assign rsp_chan.row_end    = out_row_end_ff;
   assign rsp_chan.image_end  = out_img_end_ff;
   assign rsp_chan.bad_filter = out_bad_ff;

   // Checks on the block's own logic.
   `PNGU_ASSERT_SAME(a_bad_item_clean, clock, reset,
      out_valid_ff && out_bad_ff,
      out_byte_ff == '0 && !out_row_end_ff && !out_img_end_ff,
      "error item carries data or row flags")
   `PNGU_ASSERT_SAME(a_image_end_on_row_end, clock, reset,
      out_valid_ff && out_img_end_ff, out_row_end_ff,
      "image end without row end")
   `PNGU_ASSERT_SAME(a_filter_wait_at_row_start, clock, reset,
      awaiting_ff, column_ff == '0 && left_ff == '0 && upper_left_ff == '0 && !dropping_ff,
      "filter byte awaited in the middle of a row")
   `PNGU_ASSERT_NEXT(a_store_write_through, clock, reset,
      store_wr_en && column_ff == column_in, up_byte == $past(store_wdata),
      "line store read misses a write to the same column")

endmodule

// File: dv/tb_png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Streams filter-type and sample bytes through the unfilter, predicts every
// rebuilt byte and error item with a local model of the Sub, Up, Average and
// Paeth reconstruction, and checks each result in order. A short directed
// table comes first, then random images of many widths and heights, with
// random idling on both channels, a long result hold-off and an oversized
// width.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter;
   timeunit 1ns;
   timeprecision 1ps;

   import pngu_pkg::*;

   localparam int unsigned CLOCK_PERIOD_NS = 8;
   localparam int unsigned RESET_CYCLES    = 9;
   localparam int unsigned IDLE_PERCENT    = 11;
   localparam int unsigned HOLDOFF_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned PIXEL_BYTES     = 4;
   localparam int unsigned MAX_PIXELS      = 1024;
   localparam int unsigned STORE_BYTES     = MAX_PIXELS * PIXEL_BYTES;
   localparam int unsigned RUN_LIMIT_NS    = 2_000_000;

   // Filter-type bytes that the block does not know.
   localparam logic [BYTE_W-1:0] BAD_FILTER_LOW  = 8'd5;
   localparam logic [BYTE_W-1:0] BAD_FILTER_HIGH = 8'hFF;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              frame_start;
   } stream_byte_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel_byte;
      logic              row_end;
      logic              image_end;
      logic              bad_filter;
   } pixel_result_type;

   typedef struct packed {
      stream_byte_type  item;
      logic             typed;
      pixel_result_type want;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   pngu_req_if req_if ();
   pngu_rsp_if rsp_if ();

   png_scanline_unfilter uut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if)
   );

   always #(CLOCK_PERIOD_NS / 2) clock = ~clock;

   // Mirror of the block's state, advanced once per accepted item.
   logic [BYTE_W-1:0] up_row [0:STORE_BYTES-1];
   int unsigned       written_prefix;
   logic [31:0]       left_hist;
   logic [31:0]       upleft_hist;
   logic [11:0]       column;
   logic [15:0]       rows_done;
   logic [2:0]        filter_kind;
   logic              want_filter;
   logic              skip_row;
   logic [10:0]       cfg_width;
   logic [15:0]       cfg_height;

   pixel_result_type recon_queue [$];

   // Run control shared by the two channel processes.
   logic        sender_calm   = 1'b0;
   logic        receiver_calm = 1'b0;
   int unsigned holdoff_requests = 0;
   int unsigned fault_count   = 0;
   int unsigned bytes_checked = 0;
   int unsigned rows_closed   = 0;
   int unsigned images_closed = 0;
   int unsigned rows_dropped  = 0;

   // Directed items, width 1 pixel and height 2 rows. Hand-written results
   // where they are obvious; the rest come from the predictor.
   directed_row_type directed_rows [28] = '{
      // Plain row: each byte passes through unchanged.
      '{'{FILTER_NONE,    1'b1}, 1'b0, '0},
      '{'{8'h00,          1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{'{8'hFF,          1'b0}, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0}},
      '{'{8'h80,          1'b0}, 1'b1, '{8'h80, 1'b0, 1'b0, 1'b0}},
      '{'{8'h7F,          1'b0}, 1'b1, '{8'h7F, 1'b1, 1'b0, 1'b0}},
      // Up row: sums wrap modulo 256, last byte closes the image.
      '{'{FILTER_UP,      1'b0}, 1'b0, '0},
      '{'{8'h01,          1'b0}, 1'b1, '{8'h01, 1'b0, 1'b0, 1'b0}},
      '{'{8'h01,          1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{'{8'h80,          1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{'{8'h00,          1'b0}, 1'b1, '{8'h7F, 1'b1, 1'b1, 1'b0}},
      // Bytes after the image end open a new image; Paeth reads zeros above.
      '{'{FILTER_PAETH,   1'b0}, 1'b0, '0},
      '{'{8'h10,          1'b0}, 1'b0, '0},
      '{'{8'h20,          1'b0}, 1'b0, '0},
      // Frame start in mid-row with an unknown filter type; the row is dropped.
      '{'{BAD_FILTER_HIGH, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
      '{'{8'h00,          1'b0}, 1'b0, '0},
      '{'{8'hFF,          1'b0}, 1'b0, '0},
      '{'{8'h5A,          1'b0}, 1'b0, '0},
      '{'{8'hA5,          1'b0}, 1'b0, '0},
      // Average row reads the store left by the earlier rows.
      '{'{FILTER_AVERAGE, 1'b0}, 1'b0, '0},
      '{'{8'hF0,          1'b0}, 1'b0, '0},
      '{'{8'h0F,          1'b0}, 1'b0, '0},
      '{'{8'hFF,          1'b0}, 1'b0, '0},
      '{'{8'h01,          1'b0}, 1'b0, '0},
      // Frame start on a filter byte, then a Sub row.
      '{'{FILTER_SUB,     1'b1}, 1'b0, '0},
      '{'{8'h05,          1'b0}, 1'b1, '{8'h05, 1'b0, 1'b0, 1'b0}},
      '{'{8'hFB,          1'b0}, 1'b0, '0},
      '{'{8'h01,          1'b0}, 1'b0, '0},
      '{'{8'h01,          1'b0}, 1'b0, '0}
   };

   // Clears the per-row state at the start of every row.
   function automatic void open_row();
      column      = '0;
      left_hist   = '0;
      upleft_hist = '0;
      want_filter = 1'b1;
      skip_row    = 1'b0;
   endfunction

   // Paeth choice: the neighbour nearest to a + b - c, ties to a, then b.
   function automatic logic [BYTE_W-1:0] paeth_pick(
      input logic [BYTE_W-1:0] a,
      input logic [BYTE_W-1:0] b,
      input logic [BYTE_W-1:0] c
   );
      int ia;
      int ib;
      int ic;
      int p;
      int da;
      int db;
      int dc;
      ia = a;
      ib = b;
      ic = c;
      p  = ia + ib - ic;
      da = (p > ia) ? p - ia : ia - p;
      db = (p > ib) ? p - ib : ib - p;
      dc = (p > ic) ? p - ic : ic - p;
      if (da <= db && da <= dc) begin
         return a;
      end else if (db <= dc) begin
         return b;
      end
      return c;
   endfunction

   // Advances the mirror by one accepted byte and queues the result it
   // causes, if any. A hand-written result replaces the predicted one.
   task automatic unfilter_step(
      input stream_byte_type  s,
      input logic             typed,
      input pixel_result_type typed_res
   );
      logic [12:0]       stride;
      logic [15:0]       height;
      logic [BYTE_W-1:0] a;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] c;
      logic [BYTE_W-1:0] guess;
      logic [BYTE_W-1:0] recon;
      logic              last_col;
      logic              last_row;
      pixel_result_type  res;
      // Out-of-range sizes are clamped.
      if (cfg_width == 0) begin
         stride = 13'(PIXEL_BYTES);
      end else if (cfg_width > MAX_PIXELS) begin
         stride = 13'(STORE_BYTES);
      end else begin
         stride = 13'(cfg_width) * 13'(PIXEL_BYTES);
      end
      height = (cfg_height == 0) ? 16'd1 : cfg_height;

      if (s.frame_start) begin
         rows_done = '0;
         open_row();
      end

      if (want_filter) begin
         want_filter = 1'b0;
         if (s.data_byte > FILTER_PAETH) begin
            skip_row = 1'b1;
            res      = '{8'h00, 1'b0, 1'b0, 1'b1};
            recon_queue.push_back(typed ? typed_res : res);
         end else begin
            filter_kind = s.data_byte[2:0];
         end
      end else begin
         last_col = (13'(column) + 13'd1) >= stride;
         last_row = (17'(rows_done) + 17'd1) >= 17'(height);
         if (!skip_row) begin
            a = left_hist[31:24];
            c = upleft_hist[31:24];
            b = (rows_done == 0) ? 8'h00 : up_row[column];
            case (filter_kind)
               FILTER_SUB:     guess = a;
               FILTER_UP:      guess = b;
               FILTER_AVERAGE: guess = 8'((9'(a) + 9'(b)) >> 1);
               FILTER_PAETH:   guess = paeth_pick(a, b, c);
               default:        guess = 8'h00;
            endcase
            recon = s.data_byte + guess;
            up_row[column] = recon;
            if (column == written_prefix) begin
               written_prefix++;
            end
            left_hist   = {left_hist[23:0], recon};
            upleft_hist = {upleft_hist[23:0], b};
            res = '{recon, last_col, last_col && last_row, 1'b0};
            recon_queue.push_back(typed ? typed_res : res);
         end
         if (last_col) begin
            rows_done = last_row ? 16'd0 : rows_done + 16'd1;
            open_row();
         end else begin
            column++;
         end
      end
   endtask

   // Chooses the next byte from where the stream stands. Mostly well-formed
   // rows with random content; now and then a frame start or an unknown
   // filter type. A clean stream opens on a frame start; known filters only.
   function automatic stream_byte_type pick_byte(input logic clean, input logic first);
      stream_byte_type s;
      int unsigned     roll;
      roll          = $urandom_range(999);
      s.frame_start = clean ? first : (roll < 8);
      // A row below the first may only read columns that an earlier row wrote.
      if (!want_filter && !skip_row && rows_done != 0 && column >= written_prefix) begin
         s.frame_start = 1'b1;
      end
      roll = $urandom_range(99);
      if (s.frame_start || want_filter) begin
         if (!clean && roll < 5) begin
            s.data_byte = 8'($urandom_range(BAD_FILTER_HIGH, BAD_FILTER_LOW));
         end else begin
            s.data_byte = 8'($urandom_range(FILTER_PAETH, FILTER_NONE));
         end
      end else if (roll < 8) begin
         s.data_byte = 8'h00;
      end else if (roll < 16) begin
         s.data_byte = 8'hFF;
      end else begin
         s.data_byte = 8'($urandom_range(255));
      end
      return s;
   endfunction

   // Offers one item, idling at random first, and holds it until taken.
   task automatic offer_byte(
      input stream_byte_type  s,
      input logic             typed,
      input pixel_result_type typed_res
   );
      while (!sender_calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.data_byte   <= s.data_byte;
      req_if.frame_start <= s.frame_start;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      unfilter_step(s, typed, typed_res);
   endtask

   // Stops sending and waits for every expected result, then lets the
   // pipeline settle, since a filter-type byte may still be in flight.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (recon_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes both size registers on back-to-back cycles.
   task automatic set_geometry(input logic [15:0] width_value, input logic [15:0] height_value);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_IMAGE_WIDTH;
      csr_wdata    <= width_value;
      @(posedge clock);
      csr_index    <= CSR_IMAGE_HEIGHT;
      csr_wdata    <= height_value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_width  = width_value[10:0];
      cfg_height = height_value;
   endtask

   // One stretch of random bytes under a fixed image size.
   task automatic run_phase(
      input logic [15:0] width_value,
      input logic [15:0] height_value,
      input int unsigned count,
      input logic        clean,
      input logic        squeeze
   );
      drain();
      set_geometry(width_value, height_value);
      sender_calm   = clean;
      receiver_calm = clean;
      for (int unsigned i = 0; i < count; i++) begin
         if (squeeze && i == 40) begin
            holdoff_requests++;
         end
         offer_byte(pick_byte(clean, i == 0), 1'b0, '0);
      end
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
   endtask

   // Result side: random stalls, one long hold-off on request, and the
   // in-order comparison against the predicted results.
   initial begin : result_sink
      int unsigned      holdoff_left;
      int unsigned      holdoff_served;
      pixel_result_type got;
      pixel_result_type want;
      holdoff_left   = 0;
      holdoff_served = 0;
      rsp_if.ready   = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got = '{rsp_if.pixel_byte, rsp_if.row_end, rsp_if.image_end, rsp_if.bad_filter};
            if (recon_queue.size() == 0) begin
               fault_count++;
               $display("%0t: unexpected item: pixel %02h row_end %b image_end %b bad_filter %b",
                        $time, got.pixel_byte, got.row_end, got.image_end, got.bad_filter);
            end else begin
               want = recon_queue.pop_front();
               if (got !== want) begin
                  fault_count++;
                  $display({"%0t: mismatch: expected pixel %02h row_end %b image_end %b ",
                            "bad_filter %b, got pixel %02h row_end %b image_end %b ",
                            "bad_filter %b"},
                           $time, want.pixel_byte, want.row_end, want.image_end,
                           want.bad_filter, got.pixel_byte, got.row_end, got.image_end,
                           got.bad_filter);
               end
               if (want.bad_filter) begin
                  rows_dropped++;
               end else begin
                  bytes_checked++;
               end
               rows_closed   += want.row_end;
               images_closed += want.image_end;
            end
         end
         if (holdoff_requests != holdoff_served) begin
            holdoff_left   = HOLDOFF_CYCLES;
            holdoff_served = holdoff_requests;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= receiver_calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Stimulus: reset, directed table, then random phases.
   initial begin : stimulus
      csr_write_en       = 1'b0;
      csr_index          = CSR_IMAGE_WIDTH;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.data_byte   = '0;
      req_if.frame_start = 1'b0;
      cfg_width          = 11'd1;
      cfg_height         = 16'd1;
      rows_done          = '0;
      filter_kind        = '0;
      written_prefix     = 0;
      open_row();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_geometry(16'd1, 16'd2);
      foreach (directed_rows[i]) begin
         offer_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end

      // Zero sizes count as one pixel and one row.
      run_phase(16'd0, 16'd0, 120, 1'b0, 1'b0);
      run_phase(16'd2, 16'd3, 250, 1'b0, 1'b0);
      // Tallest image, with the result side held off for a long stretch.
      run_phase(16'd3, 16'hFFFF, 200, 1'b0, 1'b1);
      // Oversized width clamps to the full store, so the row runs on; no idling.
      run_phase(16'd2047, 16'd1, 200, 1'b1, 1'b0);
      run_phase(16'd1024, 16'hFFFF, 80, 1'b0, 1'b0);
      run_phase(16'd5, 16'd4, 300, 1'b0, 1'b0);
      repeat (4) begin
         run_phase(16'($urandom_range(8, 1)), 16'($urandom_range(5, 1)),
                   $urandom_range(200, 140), 1'b0, 1'b0);
      end
      drain();

      $display("Checked %0d rebuilt bytes closing %0d rows and %0d images; %0d rows dropped",
               bytes_checked, rows_closed, images_closed, rows_dropped);
      $display("for unknown filter types, at widths from 1 to 1024 pixels, with a long stall.");
      if (fault_count == 0) begin
         $display("PASS png_scanline_unfilter");
      end else begin
         $display("FAIL png_scanline_unfilter");
      end
      $finish;
   end

   // Ends a run that hangs.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Timed out with %0d results still awaited.", recon_queue.size());
      $display("FAIL png_scanline_unfilter");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/pngu_pkg.sv
rtl/pngu_req_if.sv
rtl/pngu_rsp_if.sv
rtl/png_scanline_unfilter.sv
dv/tb_png_scanline_unfilter.sv
